>>> src/ume_pkg.sv
// Shared types and constants for the universal machine execute core.
// No dependencies.
package ume_pkg;

	localparam int OpShift = 28;
	localparam int ImmBits = 25;
	localparam logic [31:0] AllOnes = 32'hFFFF_FFFF;
	localparam logic [31:0] MaxChar = 32'd255;

	typedef enum logic [3:0] {
		OP_CMOV = 4'd0, OP_LOAD = 4'd1, OP_STORE = 4'd2, OP_ADD = 4'd3,
		OP_MUL = 4'd4, OP_DIV = 4'd5, OP_NAND = 4'd6, OP_HALT = 4'd7,
		OP_MAP = 4'd8, OP_UNMAP = 4'd9, OP_OUT = 4'd10, OP_IN = 4'd11,
		OP_LOADP = 4'd12, OP_IMM = 4'd13, OP_BAD0 = 4'd14, OP_BAD1 = 4'd15
	} opcode_t;

	typedef enum logic [3:0] {
		ACT_NONE = 4'd0, ACT_LOAD = 4'd1, ACT_STORE = 4'd2, ACT_MAP = 4'd3,
		ACT_UNMAP = 4'd4, ACT_PUT = 4'd5, ACT_GET = 4'd6, ACT_LOADP = 4'd7,
		ACT_HALT = 4'd8
	} action_t;

	typedef enum logic [2:0] {
		ERR_NONE = 3'd0, ERR_OPCODE = 3'd1, ERR_DIVZERO = 3'd2,
		ERR_OUTPUT = 3'd3, ERR_UNEXPECTED = 3'd4
	} err_t;

	typedef enum logic [1:0] {
		WAIT_NONE = 2'd0, WAIT_LOAD = 2'd1, WAIT_MAP = 2'd2, WAIT_INPUT = 2'd3
	} wait_t;

	localparam logic [1:0] ModeInstr = 2'd0;
	localparam logic [1:0] ModeMem = 2'd1;
	localparam logic [1:0] ModeCons = 2'd2;

	typedef struct packed {
		logic [1:0]  mode;
		logic [31:0] instr_word;
		logic [31:0] resp_data;
		logic [7:0]  in_byte;
		logic        in_eof;
	} in_item_t;

	typedef struct packed {
		logic [3:0]  action;
		logic [31:0] seg_id;
		logic [31:0] offset;
		logic [31:0] data_out;
		logic [31:0] next_pc;
		logic [2:0]  error;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_EXEC, ST_MUL, ST_DIV, ST_DONE
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load_in;    // capture input item
		logic exec;       // execute instruction, build result
		logic mul_start;
		logic mul_step;
		logic div_start;
		logic div_step;
		logic arith_wb;   // write multiply/divide result
	} ctrl_t;

	// datapath -> controller
	typedef struct packed {
		logic need_mul;
		logic need_div;
		logic mul_last;
		logic div_last;
	} stat_t;

endpackage

>>> src/universal_machine_execute.sv
// Top level of the universal machine execute core.
// Depends on ume_pkg, ume_ctrl, ume_dpath.
//
// Usage: one item enters on the in channel (valid/ready) and exactly one
// result item leaves on the out channel (valid/ready) for each.
// An item is an instruction word (mode 0) or a response to a pending load,
// map or console input request (modes 1 and 2).
// The item is captured, executed in the next cycle and shown the cycle
// after for most items. Multiply and divide go through a shared
// iterative unit at 4 bits a cycle in 8 steps before the result is shown.
// One item is in work at a time; the next item is taken in the same cycle
// the result transfers.
// A stalled receiver holds the result in the output register; no new item
// is taken until it transfers.
// Reset clears the registers, program counter, pending request and halt flag.
module universal_machine_execute (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  ume_pkg::in_item_t   in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output ume_pkg::out_item_t  out_data
);
	import ume_pkg::*;

	ctrl_t ctrl;
	stat_t stat;

	ume_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .stat(stat), .ctrl(ctrl)
	);

	ume_dpath u_dpath (
		.clk(clk), .arst_n(arst_n), .in_item(in_data), .ctrl(ctrl),
		.stat(stat), .out_item(out_data)
	);
endmodule

>>> src/ume_ctrl.sv
// Controller state machine for the execute core.
// Depends on ume_pkg.
module ume_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  ume_pkg::stat_t   stat,
	output ume_pkg::ctrl_t   ctrl
);
	import ume_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				if (stat.need_mul) state_d = ST_MUL;
				else if (stat.need_div) state_d = ST_DIV;
				else state_d = ST_DONE;
			end
			ST_MUL: begin
				if (stat.mul_last) state_d = ST_DONE;
			end
			ST_DIV: begin
				if (stat.div_last) state_d = ST_DONE;
			end
			ST_DONE: begin
				// a new item may enter as the result leaves
				if (out_ready) state_d = in_valid ? ST_EXEC : ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				ctrl.load_in = in_valid;
			end
			ST_EXEC: begin
				ctrl.exec = 1'b1;
				ctrl.mul_start = stat.need_mul;
				ctrl.div_start = stat.need_div;
			end
			ST_MUL: begin
				ctrl.mul_step = 1'b1;
				ctrl.arith_wb = stat.mul_last;
			end
			ST_DIV: begin
				ctrl.div_step = 1'b1;
				ctrl.arith_wb = stat.div_last;
			end
			ST_DONE: begin
				out_valid = 1'b1;
				in_ready = out_ready;
				ctrl.load_in = out_ready & in_valid;
			end
			default: ;
		endcase
	end
endmodule

>>> src/ume_dpath.sv
// Datapath: register file, program counter, wait state, shift-add multiplier
// and restoring divider, result register. Depends on ume_pkg.
module ume_dpath (
	input  logic                clk,
	input  logic                arst_n,
	input  ume_pkg::in_item_t   in_item,
	input  ume_pkg::ctrl_t      ctrl,
	output ume_pkg::stat_t      stat,
	output ume_pkg::out_item_t  out_item
);
	import ume_pkg::*;

	in_item_t   item_q;
	logic [31:0] regs_q [8];
	logic [31:0] pc_q;
	wait_t       wait_q;
	logic [2:0]  wreg_q;
	logic        halted_q;
	out_item_t   res_q;

	// iterative arithmetic: 4 bits a step, 8 steps
	logic [31:0] acc_q, opa_q, opb_q, rem_q;
	logic [2:0]  step_q;
	logic [2:0]  tgt_q;

	opcode_t     op;
	logic [2:0]  ra, rb, rc, ri;
	logic [31:0] vb, vc, va;
	logic        is_instr;

	assign op = opcode_t'(item_q.instr_word[31:OpShift]);
	assign ra = item_q.instr_word[8:6];
	assign rb = item_q.instr_word[5:3];
	assign rc = item_q.instr_word[2:0];
	assign ri = item_q.instr_word[27:ImmBits];
	assign va = regs_q[ra];
	assign vb = regs_q[rb];
	assign vc = regs_q[rc];
	assign is_instr = !halted_q && item_q.mode == ModeInstr && wait_q == WAIT_NONE;

	always_comb begin
		stat = '0;
		stat.need_mul = is_instr && op == OP_MUL;
		stat.need_div = is_instr && op == OP_DIV && vc != '0;
		stat.mul_last = step_q == 3'd7;
		stat.div_last = step_q == 3'd7;
	end

	// one multiply step: add opa * 4 low bits of opb
	logic [31:0] mul_next;
	always_comb begin
		mul_next = acc_q;
		for (int i = 0; i < 4; i++) begin
			if (opb_q[i]) mul_next = mul_next + (opa_q << i);
		end
	end

	// four restoring division steps; opa holds remaining dividend bits,
	// acc the quotient, rem the partial remainder
	logic [32:0] r_t [5];
	logic [31:0] q_t;
	always_comb begin
		r_t[0] = {1'b0, rem_q};
		q_t = acc_q;
		for (int i = 0; i < 4; i++) begin
			r_t[i+1] = {r_t[i][31:0], opa_q[31-i]};
			q_t = {q_t[30:0], 1'b0};
			if (r_t[i+1] >= {1'b0, opb_q}) begin
				r_t[i+1] = r_t[i+1] - {1'b0, opb_q};
				q_t[0] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load_in) item_q <= in_item;
		if (ctrl.mul_start) begin
			acc_q <= '0; opa_q <= vb; opb_q <= vc; step_q <= '0; tgt_q <= ra;
		end else if (ctrl.div_start) begin
			acc_q <= '0; rem_q <= '0; opa_q <= vb; opb_q <= vc; step_q <= '0;
			tgt_q <= ra;
		end else if (ctrl.mul_step) begin
			acc_q <= mul_next;
			opa_q <= opa_q << 4;
			opb_q <= opb_q >> 4;
			step_q <= step_q + 3'd1;
		end else if (ctrl.div_step) begin
			acc_q <= q_t;
			rem_q <= r_t[4][31:0];
			opa_q <= opa_q << 4;
			step_q <= step_q + 3'd1;
		end
	end

	logic [31:0] wb_val;
	assign wb_val = ctrl.mul_step ? mul_next : q_t;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) regs_q[i] <= '0;
			pc_q <= '0;
			wait_q <= WAIT_NONE;
			wreg_q <= '0;
			halted_q <= 1'b0;
			res_q <= '0;
		end else if (ctrl.arith_wb) begin
			regs_q[tgt_q] <= wb_val;
		end else if (ctrl.exec) begin
			res_q <= '0;
			if (halted_q) begin
				res_q.action <= ACT_HALT;
				res_q.next_pc <= pc_q;
			end else if (is_instr) begin
				res_q.next_pc <= pc_q + 32'd1;
				pc_q <= pc_q + 32'd1;
				unique case (op)
					OP_CMOV: if (vc != '0) regs_q[ra] <= vb;
					OP_LOAD: begin
						wait_q <= WAIT_LOAD; wreg_q <= ra;
						res_q.action <= ACT_LOAD; res_q.seg_id <= vb;
						res_q.offset <= vc;
					end
					OP_STORE: begin
						res_q.action <= ACT_STORE; res_q.seg_id <= va;
						res_q.offset <= vb; res_q.data_out <= vc;
					end
					OP_ADD: regs_q[ra] <= vb + vc;
					OP_MUL: ;
					OP_DIV: if (vc == '0) res_q.error <= ERR_DIVZERO;
					OP_NAND: regs_q[ra] <= ~(vb & vc);
					OP_HALT: begin
						halted_q <= 1'b1; res_q.action <= ACT_HALT;
					end
					OP_MAP: begin
						wait_q <= WAIT_MAP; wreg_q <= rb;
						res_q.action <= ACT_MAP; res_q.data_out <= vc;
					end
					OP_UNMAP: begin
						res_q.action <= ACT_UNMAP; res_q.seg_id <= vc;
					end
					OP_OUT: begin
						if (vc > MaxChar) res_q.error <= ERR_OUTPUT;
						else begin
							res_q.action <= ACT_PUT; res_q.data_out <= vc;
						end
					end
					OP_IN: begin
						wait_q <= WAIT_INPUT; wreg_q <= rc;
						res_q.action <= ACT_GET;
					end
					OP_LOADP: begin
						pc_q <= vc; res_q.next_pc <= vc;
						res_q.action <= ACT_LOADP; res_q.seg_id <= vb;
					end
					OP_IMM: regs_q[ri] <= {7'd0, item_q.instr_word[ImmBits-1:0]};
					default: res_q.error <= ERR_OPCODE;
				endcase
			end else if (item_q.mode == ModeMem &&
				(wait_q == WAIT_LOAD || wait_q == WAIT_MAP)) begin
				regs_q[wreg_q] <= item_q.resp_data;
				wait_q <= WAIT_NONE;
				res_q.next_pc <= pc_q;
			end else if (item_q.mode == ModeCons && wait_q == WAIT_INPUT) begin
				regs_q[wreg_q] <= item_q.in_eof ? AllOnes : {24'd0, item_q.in_byte};
				wait_q <= WAIT_NONE;
				res_q.next_pc <= pc_q;
			end else begin
				res_q.error <= ERR_UNEXPECTED;
				res_q.next_pc <= pc_q;
			end
		end
	end

	assign out_item = res_q;
endmodule
